// ===== design/tft_pkg.sv =====
// Shared types, constants and codes for the TCP flow tracker.
package tft_pkg;

  // Width of the flow's packet and byte counters; results carry the low 32 bits.
  localparam int COUNT_W = 32;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [31:0] USEC_PER_SEC = 32'd1000000;

  localparam logic [7:0] CFG_NON_HTTP_LIMIT_RST   = 8'd5;
  localparam logic [7:0] CFG_RESET_MIN_CLIENT_RST = 8'd4;

  localparam int FLAG_FIN_BIT = 0;
  localparam int FLAG_SYN_BIT = 1;
  localparam int FLAG_RST_BIT = 2;
  localparam int FLAG_ACK_BIT = 4;
  localparam logic [7:0] FLAGS_PURE_SYN = 8'h02;

  typedef enum logic [1:0] {
    VERDICT_ACCEPT   = 2'd0,
    VERDICT_DROP     = 2'd1,
    VERDICT_COMPLETE = 2'd2
  } verdict_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NON_HTTP_LIMIT   = 1'b0,
    CFG_RESET_MIN_CLIENT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] non_http_limit;
    logic [7:0] reset_min_client;
  } cfg_t;

  typedef struct packed {
    logic        from_client;
    logic [7:0]  flag_bits;
    logic [15:0] payload_len;
    logic        has_http;
    logic [31:0] cap_sec;
    logic [19:0] cap_us;
  } in_item_t;

  // Decoded event handed from the front to the back.
  typedef struct packed {
    logic        client;
    logic        rst;
    logic        ack;
    logic        fin;
    logic        pure_syn;
    logic        has_http;
    logic [15:0] len;
    logic [31:0] sec;
    logic [19:0] usec;
  } event_t;

  typedef struct packed {
    verdict_t    verdict;
    logic        keep_packet;
    logic        restarted;
    logic [31:0] rtt_us;
    logic [31:0] client_packets;
    logic [31:0] server_packets;
    logic [31:0] client_bytes;
    logic [31:0] server_bytes;
    logic        is_http;
  } out_item_t;

endpackage

// ===== design/tft_front.sv =====
// Front stage: take input beats, decode the flag byte, hand events to the queue.
module tft_front import tft_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     push,
  output event_t   push_event,
  input  logic     q_full
);

  logic   fr_valid_r, fr_valid_nxt;
  event_t fr_event_r, fr_event_nxt;
  logic   take;

  assign push     = fr_valid_r && !q_full;
  assign in_ready = !fr_valid_r || push;
  assign take     = in_valid && in_ready;
  assign push_event = fr_event_r;

  always_comb begin
    fr_event_nxt.client   = in_data.from_client;
    fr_event_nxt.rst      = in_data.flag_bits[FLAG_RST_BIT];
    fr_event_nxt.ack      = in_data.flag_bits[FLAG_ACK_BIT];
    fr_event_nxt.fin      = in_data.flag_bits[FLAG_FIN_BIT];
    fr_event_nxt.pure_syn = (in_data.flag_bits == FLAGS_PURE_SYN);
    fr_event_nxt.has_http = in_data.has_http;
    fr_event_nxt.len      = in_data.payload_len;
    fr_event_nxt.sec      = in_data.cap_sec;
    fr_event_nxt.usec     = in_data.cap_us;
  end

  always_comb begin
    if (take) begin
      fr_valid_nxt = 1'b1;
    end else if (push) begin
      fr_valid_nxt = 1'b0;
    end else begin
      fr_valid_nxt = fr_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fr_event_r <= fr_event_nxt;
    end
  end

endmodule

// ===== design/tft_queue.sv =====
// Short event queue between the front and the back.
module tft_queue import tft_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  event_t push_event,
  output logic   full,
  input  logic   pop,
  output logic   q_valid,
  output event_t q_event
);

  event_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_event = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_event;
    end
  end

endmodule

// ===== design/tft_back.sv =====
// Back: one event per cycle if output free; update flow state, register result.
module tft_back import tft_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  event_t    q_event,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [COUNT_W-1:0] cc_r, cc_nxt, sc_r, sc_nxt, ct_r, ct_nxt, st_r, st_nxt;
  logic [31:0]        syn_sec_r, syn_sec_nxt;
  logic [19:0]        syn_us_r, syn_us_nxt;
  logic [31:0]        rtt_r, rtt_nxt;
  logic               http_r, http_nxt;

  logic [COUNT_W-1:0] cc_post, sc_post, ct_post, st_post;
  logic [31:0]        syn_sec_post, rtt_post, rtt_calc;
  logic [19:0]        syn_us_post;
  logic               http_post;
  logic               count_en, keep_c, restart_c, drop_lim;
  verdict_t           verdict_c;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  assign pop       = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign drop_lim = !http_r && (cc_r >= COUNT_W'(cfg.non_http_limit));
  assign rtt_calc = (q_event.sec - syn_sec_r) * USEC_PER_SEC
                  + (32'(q_event.usec) - 32'(syn_us_r));

  // Decide the event and build the post-event flow state.
  always_comb begin
    cc_post       = cc_r;
    sc_post       = sc_r;
    ct_post       = ct_r;
    st_post       = st_r;
    syn_sec_post  = syn_sec_r;
    syn_us_post   = syn_us_r;
    rtt_post      = rtt_r;
    http_post     = http_r;
    count_en      = 1'b0;
    keep_c        = 1'b0;
    restart_c     = 1'b0;
    verdict_c     = VERDICT_ACCEPT;

    if (drop_lim) begin
      verdict_c = VERDICT_DROP;
    end else if (q_event.rst) begin
      if (cc_r < COUNT_W'(cfg.reset_min_client)) begin
        verdict_c = VERDICT_DROP;
      end else begin
        count_en  = 1'b1;
        verdict_c = VERDICT_COMPLETE;
      end
    end else if (q_event.client && cc_r == COUNT_W'(1) && q_event.ack) begin
      rtt_post = rtt_calc;
      count_en = 1'b1;
    end else if (q_event.fin) begin
      count_en  = 1'b1;
      verdict_c = VERDICT_COMPLETE;
    end else if (q_event.client && cc_r == '0) begin
      syn_sec_post  = q_event.sec;
      syn_us_post   = q_event.usec;
      count_en      = 1'b1;
    end else if (q_event.client && q_event.pure_syn) begin
      // Restart from a clean flow, then count this SYN.
      cc_post       = '0;
      sc_post       = '0;
      ct_post       = '0;
      st_post       = '0;
      rtt_post      = '0;
      http_post     = 1'b0;
      syn_sec_post  = q_event.sec;
      syn_us_post   = q_event.usec;
      count_en      = 1'b1;
      restart_c     = 1'b1;
    end else begin
      if (q_event.has_http) begin
        http_post = 1'b1;
        keep_c    = 1'b1;
      end
      count_en = 1'b1;
    end

    if (count_en) begin
      if (q_event.client) begin
        cc_post = cc_post + COUNT_W'(1);
        ct_post = ct_post + COUNT_W'(q_event.len);
      end else begin
        sc_post = sc_post + COUNT_W'(1);
        st_post = st_post + COUNT_W'(q_event.len);
      end
    end
  end

  always_comb begin
    out_data_nxt.verdict        = verdict_c;
    out_data_nxt.keep_packet    = keep_c;
    out_data_nxt.restarted      = restart_c;
    out_data_nxt.rtt_us         = rtt_post;
    out_data_nxt.client_packets = 32'(cc_post);
    out_data_nxt.server_packets = 32'(sc_post);
    out_data_nxt.client_bytes   = 32'(ct_post);
    out_data_nxt.server_bytes   = 32'(st_post);
    out_data_nxt.is_http        = http_post;
  end

  // Commit the state on pop; drop and completion clear the flow.
  always_comb begin
    cc_nxt       = cc_r;
    sc_nxt       = sc_r;
    ct_nxt       = ct_r;
    st_nxt       = st_r;
    syn_sec_nxt  = syn_sec_r;
    syn_us_nxt   = syn_us_r;
    rtt_nxt      = rtt_r;
    http_nxt     = http_r;
    if (pop) begin
      if (verdict_c != VERDICT_ACCEPT) begin
        cc_nxt       = '0;
        sc_nxt       = '0;
        ct_nxt       = '0;
        st_nxt       = '0;
        syn_sec_nxt  = '0;
        syn_us_nxt   = '0;
        rtt_nxt      = '0;
        http_nxt     = 1'b0;
      end else begin
        cc_nxt       = cc_post;
        sc_nxt       = sc_post;
        ct_nxt       = ct_post;
        st_nxt       = st_post;
        syn_sec_nxt  = syn_sec_post;
        syn_us_nxt   = syn_us_post;
        rtt_nxt      = rtt_post;
        http_nxt     = http_post;
      end
    end
  end

  always_comb begin
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r        <= '0;
      sc_r        <= '0;
      ct_r        <= '0;
      st_r        <= '0;
      syn_sec_r   <= '0;
      syn_us_r    <= '0;
      rtt_r       <= '0;
      http_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cc_r        <= cc_nxt;
      sc_r        <= sc_nxt;
      ct_r        <= ct_nxt;
      st_r        <= st_nxt;
      syn_sec_r   <= syn_sec_nxt;
      syn_us_r    <= syn_us_nxt;
      rtt_r       <= rtt_nxt;
      http_r      <= http_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= out_data_nxt;
    end
  end

  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    pop && verdict_c != VERDICT_ACCEPT |=> cc_r == '0 && sc_r == '0 && !http_r)
    else $error("flow state not cleared after drop or completion");

  a_restart_one_client: assert property (@(posedge clk) disable iff (!rst_n)
    pop && restart_c |=> cc_r == COUNT_W'(1) && sc_r == '0)
    else $error("restart left stale counters");

  a_keep_is_http: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.keep_packet |->
      out_data_r.is_http && out_data_r.verdict == VERDICT_ACCEPT)
    else $error("kept packet without HTTP mark or with an end verdict");

  a_restart_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.restarted |->
      out_data_r.client_packets == 32'd1 && out_data_r.server_packets == 32'd0)
    else $error("restart result does not show a fresh flow");

endmodule

// ===== design/tcp_flow_tracker_top.sv =====
// Top level of the TCP flow tracker: configuration registers and the front, queue and back.
//
// Follows one TCP flow, one packet event per input beat, and returns exactly one
// result beat per event, in order. Throughput is one event per clock while the
// output side is ready: the front registers each beat and decodes its flag byte,
// a two-entry queue decouples it from the back, and the back applies the event to
// the flow state (counters, SYN time, RTT, HTTP mark) in a read-modify-write of its
// registers, which is the loop that sets the rate. The RTT is one 32x20 constant
// multiply plus an add inside it. Each beat passes the front register, the queue
// and the output register. Either side may stall freely; the queue and the output
// register absorb the difference. Configuration (index 0: non-HTTP client packet
// limit, reset 5; index 1: client packets an RST needs to complete, reset 4) is
// always ready and must only be written while no event is in flight.
module tcp_flow_tracker_top import tft_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg_r, cfg_nxt;
  logic   push, q_full, pop, q_valid;
  event_t push_event, q_event;

  // Configuration writes are registered straight into the configuration register; never stall them.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NON_HTTP_LIMIT:   cfg_nxt.non_http_limit   = cfg_data;
        CFG_RESET_MIN_CLIENT: cfg_nxt.reset_min_client = cfg_data;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.non_http_limit   <= CFG_NON_HTTP_LIMIT_RST;
      cfg_r.reset_min_client <= CFG_RESET_MIN_CLIENT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Decode flag bits and hand events to the queue.
  tft_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push       (push),
    .push_event (push_event),
    .q_full     (q_full)
  );

  // Buffer decoded events so front and back stall independently.
  tft_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_event (push_event),
    .full       (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_event    (q_event)
  );

  // Advance the flow state and register the result beat.
  tft_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_event   (q_event),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
